>>> rtl/mcg128_random_with_jump_ahead_core_macros.svh
// Assertion macros shared by the checker of the generator core.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef MCG128_RANDOM_WITH_JUMP_AHEAD_CORE_MACROS_SVH
`define MCG128_RANDOM_WITH_JUMP_AHEAD_CORE_MACROS_SVH

// Consequent checked at the same edge as the antecedent.
`define MCG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("generator check failed");

// Consequent checked at the edge after the antecedent.
`define MCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("generator check failed");

`endif

>>> rtl/mcg_pkg.sv
// Shared constants and types for the 128-bit multiplicative generator core.
// No dependencies; the files that use it refer to it by scoped names.
package mcg_pkg;

  localparam int STATE_W  = 128;
  localparam int DIST_W   = 64;
  localparam int SEED_W   = 64;
  localparam int MODE_W   = 2;
  localparam int SAMPLE_W = 53;
  localparam int LIMB_W   = 32;
  localparam int PROD_W   = 2 * LIMB_W;
  localparam int CFG_IDX_W = 2;

  localparam int PAIR_COUNT = 10;
  localparam int PAIR_CNT_W = 4;

  // Fixed multiplier built from ten 13-bit digits, lowest digit first.
  localparam logic [STATE_W-1:0] MULT =
      (128'd1941 << 0)   + (128'd1821 << 13)  + (128'd3812 << 26)  +
      (128'd1310 << 39)  + (128'd68   << 52)  + (128'd2906 << 65)  +
      (128'd2335 << 78)  + (128'd2609 << 91)  + (128'd6859 << 104) +
      (128'd1999 << 117);

  // Limb pairs whose product lands below bit 128.
  localparam logic [1:0] PAIR_I [PAIR_COUNT] =
      '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] PAIR_J [PAIR_COUNT] =
      '{2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0};

  localparam logic [MODE_W-1:0] MODE_NEXT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JUMP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 2'd1;

endpackage

>>> rtl/mcg_if.sv
// Valid/ready channel interfaces for the generator core: input, result, register write.
// Depends on mcg_pkg for field widths.
interface mcg_in_if;
  logic                         valid;
  logic                         ready;
  logic [mcg_pkg::MODE_W-1:0]   mode;
  logic [mcg_pkg::DIST_W-1:0]   jump_distance;
  modport source (output valid, output mode, output jump_distance, input ready);
  modport sink   (input valid, input mode, input jump_distance, output ready);
endinterface

interface mcg_out_if;
  logic                         valid;
  logic                         ready;
  logic [mcg_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mcg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mcg_pkg::CFG_IDX_W-1:0] index;
  logic [mcg_pkg::SEED_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/mcg128_random_with_jump_ahead_core.sv
// Top level of the 128-bit multiplicative congruential generator with jump-ahead.
// Depends on mcg_pkg, the channel interfaces in mcg_if.sv and mcg_mulmod.
//
// The input channel carries a mode and a jump distance per word. Mode 0 advances
// the state by one multiplication, mode 1 multiplies it by the multiplier raised
// to the jump distance, mode 2 reloads it from the seed registers, and mode 3
// keeps it. Every input word yields one result word: the top 53 bits of the new
// state. The register channel is always ready and writes seed_low (index 0) or
// seed_high (index 1); other indexes are dropped.
// The block takes one input word at a time and is not ready again until that
// word's result is in the output register. Each 128-bit product runs on the
// shared 32 x 32 multiplier as ten partial products. A result takes P products:
// one in mode 0, and in mode 1 one per set bit of the distance plus one per bit
// below its highest set bit; modes 2 and 3 take none. The block is ready for the
// next word in the same cycle as the result enters the output register.
// Reset sets the state to 1, seed_low to 1 and seed_high to 0. A stalled
// receiver holds the result word; the next input word is still accepted and
// its result waits in the sequencer until the output register frees up.
module mcg128_random_with_jump_ahead_core (
  input  logic         clk,
  input  logic         rst_n,
  mcg_in_if.sink       in_ch,
  mcg_out_if.source    out_ch,
  mcg_cfg_if.sink      cfg_ch
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BIT  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SQR  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                         state_r;
  logic [mcg_pkg::STATE_W-1:0]    u_r;
  logic [mcg_pkg::STATE_W-1:0]    base_r;
  logic [mcg_pkg::DIST_W-1:0]     dist_r;
  logic [mcg_pkg::SEED_W-1:0]     seed_lo_r;
  logic [mcg_pkg::SEED_W-1:0]     seed_hi_r;
  logic [mcg_pkg::SAMPLE_W-1:0]   out_sample_r;
  logic                           out_valid_r;

  logic                           mm_start;
  logic                           mm_done;
  logic [mcg_pkg::STATE_W-1:0]    mm_opa;
  logic [mcg_pkg::STATE_W-1:0]    mm_product;
  logic                           out_load;

  assign mm_start = (state_r == ST_BIT) && (dist_r != '0);
  assign mm_opa   = dist_r[0] ? u_r : base_r;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  mcg_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .opa     (mm_opa),
    .opb     (base_r),
    .done    (mm_done),
    .product (mm_product)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_lo_r   <= mcg_pkg::SEED_W'(1);
      seed_hi_r   <= '0;
      u_r         <= mcg_pkg::STATE_W'(1);
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          mcg_pkg::REG_SEED_LOW:  seed_lo_r <= cfg_ch.data;
          mcg_pkg::REG_SEED_HIGH: seed_hi_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            case (in_ch.mode)
              mcg_pkg::MODE_NEXT: begin
                base_r  <= mcg_pkg::MULT;
                dist_r  <= mcg_pkg::DIST_W'(1);
                state_r <= ST_BIT;
              end
              mcg_pkg::MODE_JUMP: begin
                base_r  <= mcg_pkg::MULT;
                dist_r  <= in_ch.jump_distance;
                state_r <= ST_BIT;
              end
              mcg_pkg::MODE_LOAD: begin
                u_r     <= {seed_hi_r, seed_lo_r};
                state_r <= ST_DONE;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_BIT: begin
          if (dist_r == '0) begin
            state_r <= ST_DONE;
          end else if (dist_r[0]) begin
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_SQR;
          end
        end
        ST_MUL: begin
          if (mm_done) begin
            u_r       <= mm_product;
            dist_r[0] <= 1'b0;
            state_r   <= ST_BIT;
          end
        end
        ST_SQR: begin
          if (mm_done) begin
            base_r  <= mm_product;
            dist_r  <= dist_r >> 1;
            state_r <= ST_BIT;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_sample_r <= u_r[mcg_pkg::STATE_W-1 -: mcg_pkg::SAMPLE_W];
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

endmodule

>>> rtl/mcg_mulmod.sv
// Iterative 128 x 128 -> 128 (mod 2^128) multiplier on one shared 32 x 32 unit.
// Depends on mcg_pkg for widths and the limb pair schedule.
module mcg_mulmod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mcg_pkg::STATE_W-1:0]  opa,
  input  logic [mcg_pkg::STATE_W-1:0]  opb,
  output logic                         done,
  output logic [mcg_pkg::STATE_W-1:0]  product
);

  logic [mcg_pkg::STATE_W-1:0]    a_r;
  logic [mcg_pkg::STATE_W-1:0]    b_r;
  logic [mcg_pkg::STATE_W-1:0]    acc_r;
  logic [mcg_pkg::PROD_W-1:0]     p_r;
  logic [1:0]                     sh_r;
  logic [mcg_pkg::PAIR_CNT_W-1:0] cnt_r;
  logic                           run_r;
  logic                           pv_r;
  logic                           last_r;
  logic                           done_r;

  logic [1:0]                     li;
  logic [1:0]                     lj;
  logic [mcg_pkg::LIMB_W-1:0]     limb_a;
  logic [mcg_pkg::LIMB_W-1:0]     limb_b;
  logic [mcg_pkg::STATE_W-1:0]    p_shifted;
  logic                           cnt_last;

  always_comb begin
    li        = mcg_pkg::PAIR_I[cnt_r];
    lj        = mcg_pkg::PAIR_J[cnt_r];
    limb_a    = a_r[{li, 5'd0} +: mcg_pkg::LIMB_W];
    limb_b    = b_r[{lj, 5'd0} +: mcg_pkg::LIMB_W];
    p_shifted = {{(mcg_pkg::STATE_W - mcg_pkg::PROD_W){1'b0}}, p_r} << {sh_r, 5'd0};
    cnt_last  = (cnt_r == mcg_pkg::PAIR_CNT_W'(mcg_pkg::PAIR_COUNT - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      last_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      pv_r   <= run_r;
      last_r <= run_r && cnt_last;
      done_r <= pv_r && last_r;
      if (start) begin
        a_r   <= opa;
        b_r   <= opb;
        acc_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else begin
        if (run_r) begin
          p_r   <= mcg_pkg::PROD_W'(limb_a * limb_b);
          sh_r  <= 2'(li + lj);
          cnt_r <= cnt_r + 1'b1;
          if (cnt_last) begin
            run_r <= 1'b0;
          end
        end
        if (pv_r) begin
          acc_r <= acc_r + p_shifted;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

>>> rtl/mcg_checker.sv
// Port-level checker for the generator core, attached to the top level by bind.
// Depends on mcg_pkg and the assertion macros header.
`include "mcg128_random_with_jump_ahead_core_macros.svh"

module mcg_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mcg_pkg::SAMPLE_W-1:0] out_sample
);

  // A new result word appears only as the sequencer returns to idle.
  `MCG_ASSERT_SAME(a_rise_idle, clk, rst_n, $rose(out_valid), in_ready && !$past(in_ready))

  // An accepted word keeps the block busy on the following cycle.
  `MCG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  `MCG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  `MCG_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_sample))

endmodule

bind mcg128_random_with_jump_ahead_core mcg_checker u_mcg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample)
);

>>> test/tb_mcg128_random_with_jump_ahead_core.sv
// Self-checking testbench for mcg128_random_with_jump_ahead_core: directed and random words
// with random idling on both channels, checked against an in-bench 128-bit state predictor.
// Depends on mcg_pkg, the channel interfaces in mcg_if.sv and the generator core.
module tb_mcg128_random_with_jump_ahead_core;

  localparam logic [mcg_pkg::MODE_W-1:0]    MODE_HOLD       = 2'd3;
  localparam logic [mcg_pkg::CFG_IDX_W-1:0] REG_SPARE_TWO   = 2'd2;
  localparam logic [mcg_pkg::CFG_IDX_W-1:0] REG_SPARE_THREE = 2'd3;
  localparam int unsigned                   CYCLE_LIMIT     = 10_000_000;
  localparam int unsigned                   SETTLE_CYCLES   = 100;

  class sample_board;
    logic [mcg_pkg::STATE_W-1:0]  gen_state;
    logic [mcg_pkg::STATE_W-1:0]  step_mult;
    logic [mcg_pkg::SEED_W-1:0]   seed_lo;
    logic [mcg_pkg::SEED_W-1:0]   seed_hi;
    logic [mcg_pkg::SAMPLE_W-1:0] pending_samples[$];
    int unsigned                  mismatches;

    function new();
      int unsigned digits [10];
      digits = '{1941, 1821, 3812, 1310, 68, 2906, 2335, 2609, 6859, 1999};
      step_mult = '0;
      for (int i = 0; i < 10; i++) begin
        step_mult = step_mult + (mcg_pkg::STATE_W'(digits[i]) << (13 * i));
      end
      gen_state = 1;
      seed_lo = 1;
      seed_hi = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [mcg_pkg::CFG_IDX_W-1:0] idx,
                            logic [mcg_pkg::SEED_W-1:0] value);
      if (idx == mcg_pkg::REG_SEED_LOW) begin
        seed_lo = value;
      end else if (idx == mcg_pkg::REG_SEED_HIGH) begin
        seed_hi = value;
      end
    endfunction

    function logic [mcg_pkg::STATE_W-1:0] mult_power(logic [mcg_pkg::DIST_W-1:0] distance);
      logic [mcg_pkg::STATE_W-1:0] acc;
      logic [mcg_pkg::STATE_W-1:0] sq;
      acc = 1;
      sq = step_mult;
      for (int b = 0; b < mcg_pkg::DIST_W; b++) begin
        if (distance[b]) begin
          acc = acc * sq;
        end
        sq = sq * sq;
      end
      return acc;
    endfunction

    function void note_input(logic [mcg_pkg::MODE_W-1:0] mode,
                             logic [mcg_pkg::DIST_W-1:0] distance);
      case (mode)
        mcg_pkg::MODE_NEXT: begin
          gen_state = gen_state * step_mult;
        end
        mcg_pkg::MODE_JUMP: begin
          gen_state = gen_state * mult_power(distance);
        end
        mcg_pkg::MODE_LOAD: begin
          gen_state = {seed_hi, seed_lo};
        end
        default: begin
        end
      endcase
      pending_samples.push_back(gen_state[mcg_pkg::STATE_W-1 -: mcg_pkg::SAMPLE_W]);
    endfunction

    function void check_sample(logic [mcg_pkg::SAMPLE_W-1:0] actual);
      logic [mcg_pkg::SAMPLE_W-1:0] want;
      if (pending_samples.size() == 0) begin
        $error("sample: no word expected, actual 0x%h", actual);
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        if (want !== actual) begin
          $error("sample: expected 0x%h, actual 0x%h", want, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mcg_in_if  in_ch();
  mcg_out_if out_ch();
  mcg_cfg_if cfg_ch();

  mcg128_random_with_jump_ahead_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sample_board board = new();

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("mcg128_random_with_jump_ahead_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_sample(out_ch.sample);
    end
  end

  task automatic send_word(logic [mcg_pkg::MODE_W-1:0] mode,
                           logic [mcg_pkg::DIST_W-1:0] distance);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.jump_distance <= distance;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(mode, distance);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic [mcg_pkg::CFG_IDX_W-1:0] idx,
                         logic [mcg_pkg::SEED_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, value);
  endtask

  task automatic load_seeds(logic [mcg_pkg::SEED_W-1:0] lo, logic [mcg_pkg::SEED_W-1:0] hi);
    put_reg(mcg_pkg::REG_SEED_LOW, lo);
    put_reg(mcg_pkg::REG_SEED_HIGH, hi);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic pick_word(output logic [mcg_pkg::MODE_W-1:0] mode,
                           output logic [mcg_pkg::DIST_W-1:0] distance);
    int unsigned r;
    int unsigned bits;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      mode = mcg_pkg::MODE_NEXT;
    end else if (r < 75) begin
      mode = mcg_pkg::MODE_JUMP;
    end else if (r < 90) begin
      mode = mcg_pkg::MODE_LOAD;
    end else begin
      mode = MODE_HOLD;
    end
    distance = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 70) begin
      bits = $urandom_range(0, 10);
    end else if (r < 90) begin
      bits = $urandom_range(11, 24);
    end else begin
      bits = mcg_pkg::DIST_W;
    end
    if (mode == mcg_pkg::MODE_JUMP && bits < mcg_pkg::DIST_W) begin
      distance = distance & ((64'd1 << bits) - 64'd1);
    end
  endtask

  task automatic run_random(int unsigned count, int unsigned gaps, int unsigned stalls);
    logic [mcg_pkg::MODE_W-1:0] mode;
    logic [mcg_pkg::DIST_W-1:0] distance;
    gap_pct <= gaps;
    stall_pct <= stalls;
    for (int unsigned n = 0; n < count; n++) begin
      pick_word(mode, distance);
      send_word(mode, distance);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    gap_pct <= 20;
    stall_pct <= 20;
    in_ch.valid <= 1'b0;
    in_ch.mode <= mcg_pkg::MODE_NEXT;
    in_ch.jump_distance <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= mcg_pkg::REG_SEED_LOW;
    cfg_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset seeds and state first, then jump distances at their extremes.
    send_word(MODE_HOLD, '1);
    send_word(mcg_pkg::MODE_LOAD, '0);
    send_word(mcg_pkg::MODE_NEXT, '1);
    send_word(mcg_pkg::MODE_JUMP, 64'd0);
    send_word(mcg_pkg::MODE_JUMP, 64'd1);
    send_word(mcg_pkg::MODE_JUMP, 64'd2);
    send_word(mcg_pkg::MODE_JUMP, '1);
    send_word(mcg_pkg::MODE_JUMP, 64'h8000_0000_0000_0000);
    send_word(mcg_pkg::MODE_NEXT, '0);
    send_word(MODE_HOLD, '0);
    wait_drained();

    // Writes to the spare indexes, then all-ones seeds loaded and used in every mode.
    put_reg(REG_SPARE_TWO, '0);
    put_reg(REG_SPARE_THREE, 64'h0123_4567_89ab_cdef);
    put_reg(mcg_pkg::REG_SEED_LOW, '1);
    put_reg(mcg_pkg::REG_SEED_HIGH, '1);
    cfg_ch.valid <= 1'b0;
    send_word(mcg_pkg::MODE_LOAD, '1);
    send_word(MODE_HOLD, '0);
    send_word(mcg_pkg::MODE_NEXT, '0);
    send_word(mcg_pkg::MODE_JUMP, 64'd19);
    wait_drained();

    // A zero state must stay zero under every mode.
    load_seeds('0, '0);
    send_word(mcg_pkg::MODE_LOAD, '0);
    send_word(mcg_pkg::MODE_NEXT, '0);
    send_word(mcg_pkg::MODE_JUMP, '1);
    send_word(MODE_HOLD, '1);
    wait_drained();

    load_seeds(64'd2, 64'h8000_0000_0000_0000);
    send_word(mcg_pkg::MODE_LOAD, '0);
    send_word(mcg_pkg::MODE_NEXT, '0);
    send_word(mcg_pkg::MODE_JUMP, 64'd3);
    wait_drained();

    load_seeds({$urandom, $urandom} | 64'd1, {$urandom, $urandom});
    run_random(300, 30, 30);
    wait_drained();
    load_seeds({$urandom, $urandom}, {$urandom, $urandom});
    run_random(300, 0, 0);
    wait_drained();
    load_seeds({$urandom, $urandom} | 64'd1, {$urandom, $urandom});
    run_random(300, 10, 15);
    wait_drained();
    load_seeds({$urandom, $urandom}, {$urandom, $urandom});
    run_random(300, 0, 0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("mcg128_random_with_jump_ahead_core verification clean");
    end else begin
      $display("mcg128_random_with_jump_ahead_core verification failed");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/mcg_pkg.sv
rtl/mcg_if.sv
rtl/mcg_mulmod.sv
rtl/mcg128_random_with_jump_ahead_core.sv
rtl/mcg_checker.sv
test/tb_mcg128_random_with_jump_ahead_core.sv
